@@ rtl/core/uri_percent_decoder_unit_macros.svh @@
// ----------------------------------------------------------------------------
// uri_percent_decoder_unit_macros
// Assertion macros used by the percent decoder top level.
// ----------------------------------------------------------------------------
// Each macro builds one labeled concurrent assertion on the rising clock edge,
// disabled while reset is high.
`ifndef URI_PERCENT_DECODER_UNIT_MACROS_SVH
`define URI_PERCENT_DECODER_UNIT_MACROS_SVH

// Consequent must hold in the same cycle as the antecedent.
`define UPD_ASSERT_SAME(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define UPD_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

@@ rtl/core/upd_pkg.sv @@
// ----------------------------------------------------------------------------
// upd_pkg
// Types, constants and helper functions shared by the percent decoder modules.
// ----------------------------------------------------------------------------
`default_nettype none

package upd_pkg;

   // Character codes used by the decoder.
   localparam logic [7:0] CHAR_PERCENT = 8'h25;
   localparam logic [7:0] CHAR_PLUS    = 8'h2B;
   localparam logic [7:0] CHAR_SPACE   = 8'h20;

   // Most decoded bytes that one request can produce.
   localparam int MAX_RESULTS = 3;
   localparam int RES_CNT_W   = $clog2(MAX_RESULTS + 1);
   localparam int RES_IDX_W   = $clog2(MAX_RESULTS);

   // Depth of the queue between the front and back halves.
   localparam int QUEUE_DEPTH = 4;
   localparam int QUEUE_PTR_W = $clog2(QUEUE_DEPTH);
   localparam int QUEUE_LVL_W = $clog2(QUEUE_DEPTH + 1);

   // Escape parser phase.
   typedef enum logic [1:0] {
      PH_IDLE    = 2'd0,
      PH_PERCENT = 2'd1,
      PH_DIGIT   = 2'd2
   } phase_type;

   // One encoded input byte.
   typedef struct packed {
      logic [7:0] in_byte;
      logic       in_last;
   } req_type;

   // One decoded output byte.
   typedef struct packed {
      logic [7:0] out_byte;
      logic       out_last;
   } rsp_type;

   // All decoded bytes caused by one request, in output order.
   typedef struct packed {
      logic [MAX_RESULTS-1:0][7:0] bytes;
      logic [RES_CNT_W-1:0]        count;
      logic                        last;
   } bundle_type;

   // Queue occupancy reported to the top level.
   typedef struct packed {
      logic                   full;
      logic                   empty;
      logic [QUEUE_LVL_W-1:0] level;
   } queue_status_type;

   // True for 0-9, A-F and a-f.
   function automatic logic is_hex(input logic [7:0] c);
      is_hex = ((c >= 8'h30) && (c <= 8'h39)) ||
               ((c >= 8'h41) && (c <= 8'h46)) ||
               ((c >= 8'h61) && (c <= 8'h66));
   endfunction

   // Nibble value of a hex digit character; zero for anything else.
   function automatic logic [3:0] hex_value(input logic [7:0] c);
      logic [7:0] v;
      v = 8'h00;
      if ((c >= 8'h30) && (c <= 8'h39)) begin
         v = c - 8'h30;
      end else if ((c >= 8'h41) && (c <= 8'h46)) begin
         v = c - 8'h37;
      end else if ((c >= 8'h61) && (c <= 8'h66)) begin
         v = c - 8'h57;
      end
      hex_value = v[3:0];
   endfunction

endpackage

`default_nettype wire

@@ rtl/core/upd_front.sv @@
// ----------------------------------------------------------------------------
// upd_front
// Escape parser: classifies each accepted byte against the current phase and
// builds the group of decoded bytes that the request produces.
// ----------------------------------------------------------------------------
`default_nettype none

module upd_front (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire upd_pkg::req_type    req_data,
   input  wire logic                req_accept,
   output upd_pkg::bundle_type      bundle,
   output logic                     push
);
   import upd_pkg::*;

   phase_type  phase_ff;
   phase_type  phase_in;
   phase_type  phase_mid;
   logic [7:0] held_ff;
   logic [7:0] held_in;
   logic       b_hex;

   assign b_hex = is_hex(req_data.in_byte);

   // Next phase and held digit; a string end always returns to idle.
   always_comb begin
      phase_mid = PH_IDLE;
      held_in   = held_ff;
      unique case (phase_ff)
         PH_PERCENT: begin
            if (b_hex) begin
               phase_mid = PH_DIGIT;
               held_in   = req_data.in_byte;
            end else if (req_data.in_byte == CHAR_PERCENT) begin
               phase_mid = PH_PERCENT;
            end
         end
         PH_DIGIT: begin
            if (!b_hex && (req_data.in_byte == CHAR_PERCENT)) begin
               phase_mid = PH_PERCENT;
            end
         end
         default: begin
            if (req_data.in_byte == CHAR_PERCENT) begin
               phase_mid = PH_PERCENT;
            end
         end
      endcase
      phase_in = req_data.in_last ? PH_IDLE : phase_mid;
   end

   // Decoded bytes for this request, including the flush at string end.
   always_comb begin
      logic [RES_CNT_W-1:0] n;
      logic                 take_idle;
      bundle    = '0;
      n         = '0;
      take_idle = 1'b0;
      unique case (phase_ff)
         PH_PERCENT: begin
            if (!b_hex) begin
               bundle.bytes[n[RES_IDX_W-1:0]] = CHAR_PERCENT;
               n         = n + 1'b1;
               take_idle = 1'b1;
            end
         end
         PH_DIGIT: begin
            if (b_hex) begin
               bundle.bytes[n[RES_IDX_W-1:0]] = {hex_value(held_ff),
                                                  hex_value(req_data.in_byte)};
               n = n + 1'b1;
            end else begin
               bundle.bytes[n[RES_IDX_W-1:0]] = CHAR_PERCENT;
               n = n + 1'b1;
               bundle.bytes[n[RES_IDX_W-1:0]] = held_ff;
               n         = n + 1'b1;
               take_idle = 1'b1;
            end
         end
         default: begin
            take_idle = 1'b1;
         end
      endcase
      // Plain byte handling from idle and after a failed escape; a percent sign only opens an escape.
      if (take_idle && (req_data.in_byte != CHAR_PERCENT)) begin
         bundle.bytes[n[RES_IDX_W-1:0]] =
            (req_data.in_byte == CHAR_PLUS) ? CHAR_SPACE : req_data.in_byte;
         n = n + 1'b1;
      end
      // At string end, anything still held comes out literally.
      if (req_data.in_last) begin
         if ((phase_mid == PH_PERCENT) || (phase_mid == PH_DIGIT)) begin
            bundle.bytes[n[RES_IDX_W-1:0]] = CHAR_PERCENT;
            n = n + 1'b1;
         end
         if (phase_mid == PH_DIGIT) begin
            bundle.bytes[n[RES_IDX_W-1:0]] = held_in;
            n = n + 1'b1;
         end
      end
      bundle.count = n;
      bundle.last  = req_data.in_last;
   end

   // Only groups that carry bytes enter the queue.
   assign push = req_accept && (bundle.count != '0);

   // Parser state registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PH_IDLE;
         held_ff  <= 8'h00;
      end else if (req_accept) begin
         phase_ff <= phase_in;
         held_ff  <= held_in;
      end
   end

endmodule

`default_nettype wire

@@ rtl/core/upd_queue.sv @@
// ----------------------------------------------------------------------------
// upd_queue
// Small FIFO of decoded byte groups between the parser and the output
// sequencer, so that each side can stall on its own.
// ----------------------------------------------------------------------------
`default_nettype none

module upd_queue (
   input  wire logic                      clock,
   input  wire logic                      reset,
   input  wire logic                      push,
   input  wire upd_pkg::bundle_type       push_data,
   input  wire logic                      pop,
   output upd_pkg::bundle_type            head,
   output upd_pkg::queue_status_type      status
);
   import upd_pkg::*;

   bundle_type             entries_ff [QUEUE_DEPTH];
   logic [QUEUE_PTR_W-1:0] wr_ptr_ff;
   logic [QUEUE_PTR_W-1:0] rd_ptr_ff;
   logic [QUEUE_LVL_W-1:0] level_ff;
   logic [QUEUE_LVL_W-1:0] level_in;

   // Occupancy flags.
   assign status.level = level_ff;
   assign status.full  = (level_ff == QUEUE_LVL_W'(QUEUE_DEPTH));
   assign status.empty = (level_ff == '0);
   assign head         = entries_ff[rd_ptr_ff];

   // Level tracks pushes against pops.
   always_comb begin
      level_in = level_ff;
      if (push && !pop) begin
         level_in = level_ff + 1'b1;
      end else if (pop && !push) begin
         level_in = level_ff - 1'b1;
      end
   end

   // Pointers and level.
   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         level_ff  <= '0;
      end else begin
         if (push) begin
            wr_ptr_ff <= wr_ptr_ff + 1'b1;
         end
         if (pop) begin
            rd_ptr_ff <= rd_ptr_ff + 1'b1;
         end
         level_ff <= level_in;
      end
   end

   // Entry storage.
   always_ff @(posedge clock) begin
      if (push) begin
         entries_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

`default_nettype wire

@@ rtl/core/upd_back.sv @@
// ----------------------------------------------------------------------------
// upd_back
// Output sequencer: walks the head group into the result register one byte per
// cycle while the register drains, and releases the group as it loads its final byte.
// ----------------------------------------------------------------------------
`default_nettype none

module upd_back (
   input  wire logic                      clock,
   input  wire logic                      reset,
   input  wire upd_pkg::bundle_type       head,
   input  wire upd_pkg::queue_status_type status,
   output logic                           pop,
   output logic                           rsp_valid,
   input  wire logic                      rsp_ready,
   output upd_pkg::rsp_type               rsp_data
);
   import upd_pkg::*;

   logic [RES_IDX_W-1:0] idx_ff;
   logic [RES_IDX_W-1:0] idx_in;
   logic                 rsp_valid_ff;
   logic                 rsp_valid_in;
   rsp_type              rsp_data_ff;
   rsp_type              rsp_data_in;
   logic                 load;
   logic                 final_byte;

   // Load the result register from a non-empty queue whenever it is free or being drained.
   assign load       = !status.empty && (!rsp_valid_ff || rsp_ready);
   assign final_byte = (RES_CNT_W'(idx_ff) == (head.count - RES_CNT_W'(1)));
   assign pop        = load && final_byte;

   // Next result, index and valid.
   always_comb begin
      rsp_data_in          = rsp_data_ff;
      rsp_valid_in         = rsp_valid_ff && !rsp_ready;
      idx_in               = idx_ff;
      if (load) begin
         rsp_data_in.out_byte = head.bytes[idx_ff];
         rsp_data_in.out_last = head.last && final_byte;
         rsp_valid_in         = 1'b1;
         idx_in               = final_byte ? '0 : (idx_ff + 1'b1);
      end
   end

   // Control registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         idx_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         idx_ff       <= idx_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Result payload register.
   always_ff @(posedge clock) begin
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule

`default_nettype wire

@@ rtl/core/uri_percent_decoder_unit.sv @@
// A request's decoded bytes are written into a queue entry at its handshake,
// then loaded one at a time into the result register; further bytes of the
// same request follow one a cycle while rsp_ready stays high.
// Throughput: one request per cycle while the queue has room; one byte per
// cycle from the single result register while rsp_ready is high.
// Reset: synchronous, active high; clears the parser phase, queue and
// result valid.
// ----------------------------------------------------------------------------
// uri_percent_decoder_unit
// Streaming URL percent decoder with plus-as-space: a parser front half, a
// four-entry group queue and an output sequencer back half.
// ----------------------------------------------------------------------------
`default_nettype none

`include "uri_percent_decoder_unit_macros.svh"

module uri_percent_decoder_unit (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             req_valid,
   output logic                  req_ready,
   input  wire upd_pkg::req_type req_data,
   output logic                  rsp_valid,
   input  wire logic             rsp_ready,
   output upd_pkg::rsp_type      rsp_data
);
   import upd_pkg::*;

   bundle_type       bundle;
   bundle_type       head;
   queue_status_type q_status;
   logic             req_accept;
   logic             push;
   logic             pop;

   // Requests are taken whenever the queue has a free entry.
   assign req_ready  = !q_status.full;
   assign req_accept = req_valid && req_ready;

   // Parser front half.
   upd_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req_data   (req_data),
      .req_accept (req_accept),
      .bundle     (bundle),
      .push       (push)
   );

   // Group queue.
   upd_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_data (bundle),
      .pop       (pop),
      .head      (head),
      .status    (q_status)
   );

   // Output sequencer back half.
   upd_back u_back (
      .clock     (clock),
      .reset     (reset),
      .head      (head),
      .status    (q_status),
      .pop       (pop),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

   // The end of a string always produces at least one decoded byte.
   `UPD_ASSERT_SAME(a_last_has_bytes, clock, reset, req_accept && req_data.in_last, bundle.count != '0, "string end produced no byte")

   // The queue never holds more groups than it has entries.
   `UPD_ASSERT_SAME(a_level_bound, clock, reset, 1'b1, q_status.level <= QUEUE_LVL_W'(QUEUE_DEPTH), "queue level out of range")

   // With nothing queued, a drained result register stays empty.
   `UPD_ASSERT_NEXT(a_no_phantom, clock, reset, q_status.empty && (!rsp_valid || rsp_ready), !rsp_valid, "result without queued group")

   // A pop only happens when the queue holds a group.
   `UPD_ASSERT_SAME(a_pop_nonempty, clock, reset, pop, !q_status.empty, "pop from empty queue")

endmodule

`default_nettype wire
